// ----- hdl/smtp_chk_pkg.sv -----
// Shared types and constants for the SMTP reply code checker.
// Holds the verdict codes, parse phase encoding, character codes and widths.
// No dependencies.
package smtp_chk_pkg;

    // Payload and register widths
    localparam int BYTE_W     = 8;
    localparam int VERDICT_W  = 3;
    localparam int CODE_W     = 15;
    localparam int MAG_W      = 14;
    localparam int EXP_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int COL_W      = 8;

    // Bytes at or past this column are ignored, apart from the newline
    localparam logic [COL_W-1:0] LINE_LIMIT = COL_W'(131);
    localparam logic [COL_W-1:0] COL_MAX    = '1;
    localparam logic [COL_W-1:0] CONT_COL   = COL_W'(3);

    // Magnitude saturation and the reciprocal used for divide by 100
    localparam logic [MAG_W-1:0] MAG_MAX     = MAG_W'(9999);
    localparam int               MAG_SUM_W   = MAG_W + 3;
    localparam int               RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int               RECIP_SHIFT = 19;
    localparam int               QM_W        = 7;
    localparam int               QE_W        = 4;
    localparam logic [QM_W-1:0]  TEMP_CLASS  = QM_W'(4);

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ABORT    = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [EXP_W-1:0] EXPECTED_RST = EXP_W'(250);

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPTED       = 3'd0,
        V_NONNUM_TOL     = 3'd1,
        V_NONNUM_ABORT   = 3'd2,
        V_MISMATCH_TOL   = 3'd3,
        V_TEMPFAIL_ABORT = 3'd4,
        V_CFG_ABORT      = 3'd5
    } verdict_t;

    typedef enum logic [4:0] {
        PH_BLANKS = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_ENDED  = 5'b01000,
        PH_FAILED = 5'b10000
    } phase_t;

endpackage

// ----- hdl/smtp_reply_code_checker_core.sv -----
// SMTP reply code checker: per-byte line parser with one verdict per final line.
// A byte goes through the input register, then the result register, on its way to the verdict.
// Throughput: one byte per cycle; stalls only while the result register is held.
// Reset (aresetn low, synchronous): line state cleared, expected_code = 250,
// abort_enable = 1, no request pending in either register.
// Depends on smtp_chk_pkg.
module smtp_reply_code_checker_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [smtp_chk_pkg::BYTE_W-1:0]       s_reply_byte,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [smtp_chk_pkg::VERDICT_W-1:0]    m_verdict,
    output logic signed [smtp_chk_pkg::CODE_W-1:0] m_reply_code,
    output logic                                  m_send_quit,
    input  logic                                  cfg_we,
    input  logic [smtp_chk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smtp_chk_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import smtp_chk_pkg::*;

    // Configuration registers
    logic [EXP_W-1:0] expected_reg;
    logic             abort_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Line state
    logic [COL_W-1:0] column_reg, column_next;
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             cont_reg, cont_next;

    // Result register
    logic                     out_valid_reg, out_valid_next;
    verdict_t                 verdict_reg, verdict_next;
    logic signed [CODE_W-1:0] code_reg, code_next;
    logic                     quit_reg, quit_next;

    logic out_free;
    logic proceed;
    logic is_nl;
    logic is_blank;
    logic is_digit;
    logic [MAG_W-1:0]     digit_val;
    logic [MAG_SUM_W-1:0] mag_sum;
    logic [MAG_W+RECIP_W-1:0] qm_prod;
    logic [EXP_W+RECIP_W-1:0] qe_prod;
    logic [QM_W-1:0]      qm;
    logic [QE_W-1:0]      qe;
    logic                 numeric;
    logic                 exact_match;
    logic                 class_match;
    logic                 temp_class;

    assign out_free = !out_valid_reg || m_ready;
    assign proceed  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid      = out_valid_reg;
    assign m_verdict    = verdict_reg;
    assign m_reply_code = code_reg;
    assign m_send_quit  = quit_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= EXPECTED_RST;
            abort_reg    <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_EXPECTED: expected_reg <= cfg_wdata[EXP_W-1:0];
                REG_ABORT:    abort_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_reply_byte;
        end
    end

    // Character classes
    always_comb begin
        is_nl     = (in_byte_reg == CH_NL);
        is_blank  = (in_byte_reg inside {8'd32, [8'd9:8'd13]});
        is_digit  = (in_byte_reg inside {[8'd48:8'd57]});
        digit_val = MAG_W'(in_byte_reg - CH_ZERO);
        mag_sum   = (MAG_SUM_W'(mag_reg) << 3) + (MAG_SUM_W'(mag_reg) << 1)
                  + MAG_SUM_W'(digit_val);
    end

    // Verdict arithmetic: hundreds class by reciprocal multiply
    always_comb begin
        qm_prod     = (MAG_W+RECIP_W)'(mag_reg) * (MAG_W+RECIP_W)'(RECIP_100);
        qe_prod     = (EXP_W+RECIP_W)'(expected_reg) * (EXP_W+RECIP_W)'(RECIP_100);
        qm          = qm_prod[RECIP_SHIFT +: QM_W];
        qe          = qe_prod[RECIP_SHIFT +: QE_W];
        numeric     = (phase_reg == PH_DIGITS) || (phase_reg == PH_ENDED);
        // negative codes match only through zero
        exact_match = neg_reg ? ((mag_reg == '0) && (expected_reg == '0))
                              : (mag_reg == MAG_W'(expected_reg));
        class_match = (qm == QM_W'(qe)) && (!neg_reg || (qm == '0));
        temp_class  = !neg_reg && (qm == TEMP_CLASS);
    end

    // Line state update and result build
    always_comb begin
        column_next    = column_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        cont_next      = cont_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        verdict_next   = verdict_reg;
        code_next      = code_reg;
        quit_next      = quit_reg;

        if (proceed) begin
            if (!is_nl) begin
                if (column_reg < LINE_LIMIT) begin
                    if (column_reg == CONT_COL && in_byte_reg == CH_MINUS) begin
                        cont_next = 1'b1;
                    end
                    case (phase_reg)
                        PH_BLANKS: begin
                            if (is_blank) begin
                                phase_next = PH_BLANKS;
                            end else if (in_byte_reg == CH_PLUS ||
                                         in_byte_reg == CH_MINUS) begin
                                neg_next   = (in_byte_reg == CH_MINUS);
                                phase_next = PH_SIGN;
                            end else if (is_digit) begin
                                mag_next   = digit_val;
                                phase_next = PH_DIGITS;
                            end else begin
                                phase_next = PH_FAILED;
                            end
                        end
                        PH_SIGN: begin
                            if (is_digit) begin
                                mag_next   = digit_val;
                                phase_next = PH_DIGITS;
                            end else begin
                                phase_next = PH_FAILED;
                            end
                        end
                        PH_DIGITS: begin
                            if (is_digit) begin
                                mag_next = (mag_sum > MAG_SUM_W'(MAG_MAX)) ? MAG_MAX
                                                                            : mag_sum[MAG_W-1:0];
                            end else begin
                                phase_next = PH_ENDED;
                            end
                        end
                        default: ;
                    endcase
                end
                if (column_reg != COL_MAX) begin
                    column_next = column_reg + 1'b1;
                end
            end else begin
                // newline: one verdict for a final line, and the line state clears
                if (!cont_reg) begin
                    out_valid_next = 1'b1;
                    quit_next      = 1'b0;
                    code_next      = '0;
                    if (numeric) begin
                        code_next = neg_reg ? -CODE_W'(signed'({1'b0, mag_reg}))
                                            : CODE_W'(signed'({1'b0, mag_reg}));
                        if (exact_match || class_match) begin
                            verdict_next = V_ACCEPTED;
                        end else begin
                            quit_next = 1'b1;
                            if (!abort_reg) begin
                                verdict_next = V_MISMATCH_TOL;
                            end else if (temp_class) begin
                                verdict_next = V_TEMPFAIL_ABORT;
                            end else begin
                                verdict_next = V_CFG_ABORT;
                            end
                        end
                    end else begin
                        verdict_next = abort_reg ? V_NONNUM_ABORT : V_NONNUM_TOL;
                    end
                end
                column_next = '0;
                phase_next  = PH_BLANKS;
                neg_next    = 1'b0;
                mag_next    = '0;
                cont_next   = 1'b0;
            end
        end
    end

    // Line state and result control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            phase_reg     <= PH_BLANKS;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            cont_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            column_reg    <= column_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            cont_reg      <= cont_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
        code_reg    <= code_next;
        quit_reg    <= quit_next;
    end

    // Checks
    a_quit_matches_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_send_quit == (m_verdict == V_MISMATCH_TOL ||
                                     m_verdict == V_TEMPFAIL_ABORT ||
                                     m_verdict == V_CFG_ABORT)))
        else $error("send_quit disagrees with verdict");

    a_nonnumeric_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_verdict == V_NONNUM_TOL || m_verdict == V_NONNUM_ABORT))
        |-> (m_reply_code == '0))
        else $error("non-numeric verdict with nonzero code");

    a_newline_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && is_nl) |=> (column_reg == '0 && phase_reg == PH_BLANKS && !cont_reg))
        else $error("line state not cleared after newline");

    a_result_only_on_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg && !(proceed && is_nl)) |=> !out_valid_reg)
        else $error("result produced without a final newline");

endmodule

// ----- verif/smtp_reply_code_checker_core_test.sv -----
// Self-checking testbench for smtp_reply_code_checker_core: directed and random reply streams in,
// verdicts checked against an in-bench line parser.
// Depends on smtp_chk_pkg and smtp_reply_code_checker_core.
module smtp_reply_code_checker_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smtp_chk_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int N_PHASES        = 8;
    localparam int PHASE_BYTES     = 130;
    localparam int SQUEEZE_LINES   = 80;
    localparam int SQUEEZE_PHASE   = 2;
    localparam int SETTLE_CYCLES   = 8;

    // Extra character codes used by the line parser and the stimulus
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CH_HIGH  = 8'hFF;

    typedef struct packed {
        verdict_t                  verdict;
        logic signed [CODE_W-1:0]  code;
        logic                      quit;
    } reply_verdict_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [BYTE_W-1:0]              s_reply_byte = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [VERDICT_W-1:0]           m_verdict;
    logic signed [CODE_W-1:0]       m_reply_code;
    logic                           m_send_quit;
    logic                           cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]           cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_wdata = '0;

    // Bytes waiting to be offered, and verdicts the parser expects
    logic [BYTE_W-1:0] outbound_bytes[$];
    logic [BYTE_W-1:0] line_buf[$];
    reply_verdict_t    pending_verdicts[$];

    // Parser copy of the block's line state and registers
    logic [COL_W-1:0]  line_col = '0;
    phase_t            num_phase = PH_BLANKS;
    logic              num_neg = 1'b0;
    int                num_mag = 0;
    logic              cont_line = 1'b0;
    logic [EXP_W-1:0]  exp_code = EXPECTED_RST;
    logic              abort_on = 1'b1;

    // Run bookkeeping
    int  cycle_cnt = 0;
    int  mismatch_cnt = 0;
    int  bytes_queued = 0;
    int  bytes_taken = 0;
    int  cont_skips = 0;
    int  settings_cnt = 0;
    int  verdict_tally[6] = '{default: 0};
    int  stall_run = 0;
    int  stall_max = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  req_taken = 1'b0;
    bit  idle_on = 1'b1;
    bit  squeeze_go = 1'b0;
    bit  hold_off = 1'b0;

    smtp_reply_code_checker_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_reply_byte (s_reply_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_verdict    (m_verdict),
        .m_reply_code (m_reply_code),
        .m_send_quit  (m_send_quit),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d bytes taken",
                     cycle_cnt, bytes_taken, bytes_queued);
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit is_digit(input logic [BYTE_W-1:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_idle();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        mismatch_cnt++;
    endtask

    // Line parser: advance on one byte, queue a verdict when a final line ends
    task automatic take_reply_byte(input logic [BYTE_W-1:0] b);
        reply_verdict_t v;
        int             code;
        int             want;
        if (b != CH_NL) begin
            if (line_col < LINE_LIMIT) begin
                if (line_col == CONT_COL && b == CH_MINUS)
                    cont_line = 1'b1;
                case (num_phase)
                    PH_BLANKS: begin
                        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
                            num_phase = PH_BLANKS;
                        end else if (b == CH_PLUS || b == CH_MINUS) begin
                            num_neg = (b == CH_MINUS);
                            num_phase = PH_SIGN;
                        end else if (is_digit(b)) begin
                            num_mag = int'(b - CH_ZERO);
                            num_phase = PH_DIGITS;
                        end else begin
                            num_phase = PH_FAILED;
                        end
                    end
                    PH_SIGN: begin
                        if (is_digit(b)) begin
                            num_mag = int'(b - CH_ZERO);
                            num_phase = PH_DIGITS;
                        end else begin
                            num_phase = PH_FAILED;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit(b)) begin
                            num_mag = num_mag * 10 + int'(b - CH_ZERO);
                            if (num_mag > int'(MAG_MAX))
                                num_mag = int'(MAG_MAX);
                        end else begin
                            num_phase = PH_ENDED;
                        end
                    end
                    default: begin
                        num_phase = num_phase;
                    end
                endcase
            end
            if (line_col != COL_MAX)
                line_col++;
            return;
        end
        // Newline: continuation lines end silently
        if (cont_line) begin
            cont_skips++;
        end else begin
            v.quit = 1'b0;
            code = 0;
            if (num_phase == PH_DIGITS || num_phase == PH_ENDED) begin
                code = num_neg ? -num_mag : num_mag;
                want = int'(exp_code);
                // Division truncates toward zero, same as the hundreds class
                if (code == want || code / 100 == want / 100) begin
                    v.verdict = V_ACCEPTED;
                end else begin
                    v.quit = 1'b1;
                    if (!abort_on)
                        v.verdict = V_MISMATCH_TOL;
                    else if (code / 100 == int'(TEMP_CLASS))
                        v.verdict = V_TEMPFAIL_ABORT;
                    else
                        v.verdict = V_CFG_ABORT;
                end
            end else begin
                v.verdict = abort_on ? V_NONNUM_ABORT : V_NONNUM_TOL;
            end
            v.code = CODE_W'(code);
            pending_verdicts.push_back(v);
            verdict_tally[int'(v.verdict)]++;
        end
        line_col = '0;
        num_phase = PH_BLANKS;
        num_neg = 1'b0;
        num_mag = 0;
        cont_line = 1'b0;
    endtask

    // Driver: one request per accepted byte, valid held until taken
    always @(negedge aclk) begin
        if (!s_valid || req_taken) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (outbound_bytes.size() != 0) begin
                s_valid <= 1'b1;
                s_reply_byte <= outbound_bytes.pop_front();
                gap_left = idle_on ? pick_idle() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver stalls; the hold-off overrides everything
    always @(negedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_on)
                stall_left = pick_idle();
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (squeeze_go);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Monitor: check results first, then feed accepted bytes to the parser
    always @(posedge aclk) begin
        reply_verdict_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict %0d with none pending", m_verdict));
                end else begin
                    got = pending_verdicts.pop_front();
                    if (m_verdict !== got.verdict)
                        report_mismatch($sformatf("verdict %0d, want %0d",
                                                  m_verdict, got.verdict));
                    if (m_reply_code !== got.code)
                        report_mismatch($sformatf("reply_code %0d, want %0d",
                                                  m_reply_code, got.code));
                    if (m_send_quit !== got.quit)
                        report_mismatch($sformatf("send_quit %0b, want %0b",
                                                  m_send_quit, got.quit));
                end
            end
            if (s_valid && s_ready) begin
                take_reply_byte(s_reply_byte);
                bytes_taken++;
                req_taken = 1'b1;
            end
            if (s_valid && !s_ready) begin
                stall_run++;
                if (stall_run > stall_max)
                    stall_max = stall_run;
            end else begin
                stall_run = 0;
            end
        end
    end

    // Line building
    task automatic end_line();
        line_buf.push_back(CH_NL);
        bytes_queued += line_buf.size();
        while (line_buf.size() != 0)
            outbound_bytes.push_back(line_buf.pop_front());
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic queue_str(input string s);
        push_str(s);
        end_line();
    endtask

    task automatic push_text(input int n);
        logic [BYTE_W-1:0] b;
        repeat (n) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == CH_NL)
                b = CH_HIGH;
            line_buf.push_back(b);
        end
    endtask

    task automatic push_blanks(input int n);
        logic [BYTE_W-1:0] b;
        repeat (n) begin
            b = ($urandom_range(0, 1) == 0) ? CH_SPACE
                                            : BYTE_W'($urandom_range(CH_TAB, CH_CR));
            if (b == CH_NL)
                b = CH_SPACE;
            line_buf.push_back(b);
        end
    endtask

    task automatic push_num(input int unsigned v, input int pad);
        string digits;
        digits = $sformatf("%0d", v);
        for (int i = digits.len(); i < pad; i++)
            line_buf.push_back(CH_ZERO);
        for (int i = 0; i < digits.len(); i++)
            line_buf.push_back(digits[i]);
    endtask

    // Reply numbers: mostly near the expected code, some far, some oversized
    function automatic int unsigned pick_code();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return exp_code;
        if (roll < 50)
            return (exp_code / 100) * 100 + $urandom_range(0, 99);
        if (roll < 65)
            return $urandom_range(400, 499);
        if (roll < 80)
            return $urandom_range(0, 999);
        if (roll < 90)
            return $urandom_range(0, 99);
        return $urandom_range(1000, 99999999);
    endfunction

    // One reply: optional continuation lines, then a final line
    task automatic queue_reply();
        int unsigned n_cont;
        int unsigned roll;
        n_cont = 0;
        if ($urandom_range(0, 1) == 1)
            n_cont = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 8 : 3);
        repeat (n_cont) begin
            push_num($urandom_range(100, 599), 3);
            line_buf.push_back(CH_MINUS);
            push_text($urandom_range(0, 16));
            end_line();
        end
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            if ($urandom_range(0, 3) == 0)
                push_blanks($urandom_range(1, 3));
            roll = $urandom_range(0, 9);
            if (roll == 0)
                line_buf.push_back(CH_PLUS);
            else if (roll == 1)
                line_buf.push_back(CH_MINUS);
            push_num(pick_code(), ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : 0);
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                line_buf.push_back(CH_SPACE);
                push_text($urandom_range(0, 20));
            end else if (roll < 75) begin
                push_text($urandom_range(1, 6));
            end else if (roll < 96) begin
                push_text(0);
            end else begin
                // runs past the column limit, and at times past the column counter ceiling
                push_text($urandom_range(130, 300));
            end
        end else if (roll < 86) begin
            line_buf.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
            push_text($urandom_range(0, 5));
        end else if (roll < 89) begin
            // number starts beyond the column limit, so it is never seen
            push_blanks(int'(LINE_LIMIT) + $urandom_range(0, 4));
            push_num(exp_code, 0);
        end else if (roll < 93) begin
            push_text(0);
        end else begin
            push_text($urandom_range(1, 20));
        end
        end_line();
    endtask

    // Register writes, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        if (idx == REG_EXPECTED)
            exp_code = EXP_W'(val);
        else
            abort_on = val[0];
        @(posedge aclk);
    endtask

    task automatic apply_settings(input int unsigned code, input int unsigned abort);
        write_reg(REG_EXPECTED, code);
        write_reg(REG_ABORT, abort);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_cnt++;
    endtask

    // Wait until every byte is taken and every verdict has come out
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (bytes_taken != bytes_queued || pending_verdicts.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int start;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lines under the reset settings
        queue_str("250");
        queue_str("");
        queue_str("25");
        queue_str("421 busy");
        queue_str("250-more");
        push_str(" \t+299");
        line_buf.push_back(CH_NUL);
        end_line();
        queue_str("-");
        queue_str("99999");
        queue_str("-99999");
        line_buf.push_back(CH_NUL);
        end_line();
        line_buf.push_back(CH_HIGH);
        end_line();
        wait_drained();

        // Tolerant mode, small expected code: sign and class corners
        apply_settings(50, 0);
        queue_str("-50");
        queue_str("450");
        queue_str("abc");
        queue_str("-7");
        wait_drained();

        // Random phases over several settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: apply_settings(999, 1);
                1: apply_settings(0, 0);
                2: apply_settings(421, 1);
                3: apply_settings(0, 1);
                4: apply_settings(999, 0);
                7: apply_settings(250, 1);
                default: apply_settings($urandom_range(0, 999), $urandom_range(0, 1));
            endcase
            idle_on = (ph != SQUEEZE_PHASE && ph != 6);
            if (ph == SQUEEZE_PHASE) begin
                squeeze_go = 1'b1;
                repeat (SQUEEZE_LINES) begin
                    push_num(pick_code(), 0);
                    end_line();
                end
            end else begin
                start = bytes_queued;
                while (bytes_queued - start < PHASE_BYTES)
                    queue_reply();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d reply bytes over %0d settings, %0d continuation lines,",
                 bytes_taken, settings_cnt, cont_skips);
        $display("verdicts 0..5: %0d %0d %0d %0d %0d %0d, longest input stall %0d cycles",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2],
                 verdict_tally[3], verdict_tally[4], verdict_tally[5], stall_max);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
